FILE: hw/rtl/context_keyed_value_table_defines.svh
// assertion macros used by context_keyed_value_table.sv
`ifndef CONTEXT_KEYED_VALUE_TABLE_DEFINES_SVH
`define CONTEXT_KEYED_VALUE_TABLE_DEFINES_SVH
`ifndef SYNTH
`define CKVT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define CKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CKVT_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define CKVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/ckvt_pkg.sv
`default_nettype none
package ckvt_pkg;

   localparam int CONTEXTS_DEFAULT = 16;
   localparam int ENTRIES_DEFAULT  = 256;

   localparam int KEY_W      = 64;
   localparam int VALUE_W    = 31;
   localparam int TOKEN_W    = 32;
   localparam int INDEX_W    = 5;
   localparam int CMD_W      = 3;
   localparam int DATA_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TOKEN_W-1:0] SEED_DEFAULT = 32'd1001;
   localparam logic [TOKEN_W-1:0] LFSR_MASK    = 32'h8020_0003;

   // register index, taken from paddr[2]
   localparam logic [0:0] CSR_TOKEN_SEED = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER = 3'd0,
      CMD_LOOKUP   = 3'd1,
      CMD_REMOVE   = 3'd2,
      CMD_OPEN     = 3'd3,
      CMD_CLOSE    = 3'd4
   } cmd_type;

   // galois lfsr, taps 32 22 2 1, shifting right
   function automatic logic [TOKEN_W-1:0] lfsr_step(input logic [TOKEN_W-1:0] s);
      logic [TOKEN_W-1:0] shifted;
      shifted = s >> 1;
      lfsr_step = s[0] ? (shifted ^ LFSR_MASK) : shifted;
   endfunction

   // a zero seed would lock the lfsr up
   function automatic logic [TOKEN_W-1:0] seed_load(input logic [TOKEN_W-1:0] s);
      seed_load = (s == '0) ? SEED_DEFAULT : s;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ckvt_entry_ram.sv
`default_nettype none
module ckvt_entry_ram
   import ckvt_pkg::*;
#(
   parameter int DEPTH  = CONTEXTS_DEFAULT * ENTRIES_DEFAULT,
   parameter int ADDR_W = $clog2(CONTEXTS_DEFAULT * ENTRIES_DEFAULT)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [KEY_W-1:0]   wr_key,
   input  wire logic [VALUE_W-1:0] wr_value,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [KEY_W-1:0]   rd_key,
   output logic      [VALUE_W-1:0] rd_value
);

   logic [KEY_W-1:0]   key_mem   [DEPTH];
   logic [VALUE_W-1:0] value_mem [DEPTH];
   logic [KEY_W-1:0]   rd_key_ff;
   logic [VALUE_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_value_ff <= value_mem[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/context_keyed_value_table.sv
`default_nettype none
`include "context_keyed_value_table_defines.svh"
// keyed value table with CONTEXTS contexts of up to ENTRIES (key, value) pairs each.
// an item is taken when start is high and busy is low; busy then stays high until the
// result has been produced. every item yields exactly one result, shown for a single
// cycle with rsp_valid high; the receiver cannot stall it, so it must take the result
// in that cycle. register, close and invalid commands finish in the dispatch state,
// which sets the result strobe. lookup and remove walk the context's entries one per
// cycle through the single read port of the entry memory, up to the entries held by
// the context (at most ENTRIES); a remove then moves the last entry into the hole.
// open walks the slot valid bits one per cycle, from slot 0 up to the last slot.
// tokens come from a 32-bit galois lfsr (mask 0x80200003) that steps once per
// successful open; the token_seed register at byte address 0 reloads it when written,
// with a zero seed replaced by 1001. configuration must only be written while idle.
module context_keyed_value_table
   import ckvt_pkg::*;
#(
   parameter int CONTEXTS = CONTEXTS_DEFAULT,
   parameter int ENTRIES  = ENTRIES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [CMD_W-1:0]      req_cmd,
   input  wire logic [INDEX_W-1:0]    req_ctx_index,
   input  wire logic [TOKEN_W-1:0]    req_ctx_token,
   input  wire logic [KEY_W-1:0]      req_key,
   input  wire logic signed [DATA_W-1:0] req_value_in,
   // result channel
   output logic                       rsp_valid,
   output logic                       rsp_status,
   output logic      [INDEX_W-1:0]    rsp_ctx_index_out,
   output logic      [TOKEN_W-1:0]    rsp_ctx_token_out,
   output logic      [KEY_W-1:0]      rsp_key_out,
   output logic signed [DATA_W-1:0]   rsp_value_out,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0]     pwdata,
   output logic      [DATA_W-1:0]     prdata,
   output logic                       pready
);

   localparam int CTX_W     = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
   localparam int ENT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int ADDR_W    = CTX_W + ENT_W;
   localparam int MEM_DEPTH = CONTEXTS * (2 ** ENT_W);

   localparam logic [INDEX_W:0]  CTX_LIMIT = (INDEX_W + 1)'(CONTEXTS);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(ENTRIES);
   localparam logic [CTX_W-1:0]  CTX_LAST  = CTX_W'(CONTEXTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_OPEN_SCAN
   } state_type;

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [ENT_W-1:0]   pend_pos_ff, pend_pos_in;
   logic [ENT_W-1:0]   hole_ff, hole_in;
   logic [CTX_W-1:0]   scan_ff, scan_in;
   logic [TOKEN_W-1:0] lfsr_ff, lfsr_in;
   logic [TOKEN_W-1:0] seed_ff, seed_in;
   logic               slot_valid_ff [CONTEXTS];
   logic               slot_valid_in [CONTEXTS];
   logic [TOKEN_W-1:0] slot_token_ff [CONTEXTS];
   logic [TOKEN_W-1:0] slot_token_in [CONTEXTS];
   logic [CNT_W-1:0]   slot_count_ff [CONTEXTS];
   logic [CNT_W-1:0]   slot_count_in [CONTEXTS];
   logic               rsp_valid_ff, rsp_valid_in;

   // latched item and result payload
   cmd_type            cmd_ff, cmd_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [TOKEN_W-1:0] tok_ff, tok_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [TOKEN_W-1:0] rsp_tok_ff, rsp_tok_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [DATA_W-1:0]  rsp_val_ff, rsp_val_in;

   // entry memory port
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [KEY_W-1:0]   ram_wr_key;
   logic [VALUE_W-1:0] ram_wr_value;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [KEY_W-1:0]   rd_key;
   logic [VALUE_W-1:0] rd_value;

   logic               accept;
   logic               csr_wr;
   logic [CTX_W-1:0]   sel;
   logic               in_range;
   logic               ctx_ok;
   logic [CNT_W-1:0]   cur_cnt;
   logic [ENT_W-1:0]   last_pos;
   logic               key_hit;
   logic [TOKEN_W-1:0] lfsr_nxt;

   ckvt_entry_ram #(
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_entry_ram (
      .clock    (clock),
      .wr_en    (ram_wr_en),
      .wr_addr  (ram_wr_addr),
      .wr_key   (ram_wr_key),
      .wr_value (ram_wr_value),
      .rd_en    (ram_rd_en),
      .rd_addr  (ram_rd_addr),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   assign accept = start && !busy;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == CSR_TOKEN_SEED);

   // context check for the latched item; out-of-range slots never pass
   assign sel      = idx_ff[CTX_W-1:0];
   assign in_range = {1'b0, idx_ff} < CTX_LIMIT;
   assign ctx_ok   = in_range && slot_valid_ff[sel] && (slot_token_ff[sel] == tok_ff);
   assign cur_cnt  = slot_count_ff[sel];
   assign last_pos = ENT_W'(cur_cnt - CNT_W'(1));

   // the shared key comparator, fed by the memory read register
   assign key_hit  = pend_ff && (rd_key == key_ff);
   assign lfsr_nxt = lfsr_step(lfsr_ff);

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      pend_pos_in   = pend_pos_ff;
      hole_in       = hole_ff;
      scan_in       = scan_ff;
      lfsr_in       = lfsr_ff;
      seed_in       = seed_ff;
      slot_valid_in = slot_valid_ff;
      slot_token_in = slot_token_ff;
      slot_count_in = slot_count_ff;
      rsp_valid_in  = 1'b0;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      tok_in        = tok_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_tok_in    = rsp_tok_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_val_in    = rsp_val_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = {sel, cur_cnt[ENT_W-1:0]};
      ram_wr_key    = key_ff;
      ram_wr_value  = val_ff[VALUE_W-1:0];
      ram_rd_en     = 1'b0;
      ram_rd_addr   = {sel, issue_ff[ENT_W-1:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_cmd);
               idx_in   = req_ctx_index;
               tok_in   = req_ctx_token;
               key_in   = req_key;
               val_in   = req_value_in;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            // default result: failure, echoed context, no key, no value
            rsp_status_in = 1'b1;
            rsp_idx_in    = idx_ff;
            rsp_tok_in    = tok_ff;
            rsp_key_in    = '0;
            rsp_val_in    = '1;
            issue_in      = '0;
            pend_in       = 1'b0;
            scan_in       = '0;
            unique case (cmd_ff)
               CMD_REGISTER: begin
                  if (ctx_ok && !val_ff[DATA_W-1] && (cur_cnt < CNT_FULL)) begin
                     ram_wr_en          = 1'b1;
                     slot_count_in[sel] = cur_cnt + CNT_W'(1);
                     rsp_status_in      = 1'b0;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               CMD_LOOKUP: begin
                  if (ctx_ok) begin
                     rsp_key_in = key_ff;
                     state_in   = ST_SCAN;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               CMD_REMOVE: begin
                  rsp_key_in = key_ff;
                  if (ctx_ok) begin
                     state_in = ST_SCAN;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               CMD_OPEN: begin
                  rsp_idx_in = '0;
                  rsp_tok_in = '0;
                  state_in   = ST_OPEN_SCAN;
               end
               CMD_CLOSE: begin
                  if (ctx_ok) begin
                     slot_valid_in[sel] = 1'b0;
                     slot_count_in[sel] = '0;
                     rsp_status_in      = 1'b0;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end

         ST_SCAN: begin
            // one read issued per cycle, compared in the cycle after
            if (key_hit) begin
               pend_in = 1'b0;
               if (cmd_ff == CMD_LOOKUP) begin
                  rsp_status_in = 1'b0;
                  rsp_val_in    = {1'b0, rd_value};
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  hole_in  = pend_pos_ff;
                  state_in = ST_MOVE_RD;
               end
            end else if (issue_ff >= cur_cnt) begin
               // every entry compared, no match
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               issue_in    = issue_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_pos_in = issue_ff[ENT_W-1:0];
            end
         end

         ST_MOVE_RD: begin
            // fetch the last entry to fill the hole
            ram_rd_en   = 1'b1;
            ram_rd_addr = {sel, last_pos};
            state_in    = ST_MOVE_WR;
         end

         ST_MOVE_WR: begin
            ram_wr_en          = 1'b1;
            ram_wr_addr        = {sel, hole_ff};
            ram_wr_key         = rd_key;
            ram_wr_value       = rd_value;
            slot_count_in[sel] = cur_cnt - CNT_W'(1);
            rsp_status_in      = 1'b0;
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end

         ST_OPEN_SCAN: begin
            // lowest free slot wins
            if (!slot_valid_ff[scan_ff]) begin
               slot_valid_in[scan_ff] = 1'b1;
               slot_token_in[scan_ff] = lfsr_nxt;
               slot_count_in[scan_ff] = '0;
               lfsr_in                = lfsr_nxt;
               rsp_status_in          = 1'b0;
               rsp_idx_in             = INDEX_W'(scan_ff);
               rsp_tok_in             = lfsr_nxt;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end else if (scan_ff == CTX_LAST) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               scan_in = scan_ff + CTX_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // seed write reloads the token generator at once
      if (csr_wr) begin
         seed_in = pwdata;
         lfsr_in = seed_load(pwdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         scan_ff      <= '0;
         lfsr_ff      <= SEED_DEFAULT;
         seed_ff      <= SEED_DEFAULT;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CONTEXTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
            slot_count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         scan_ff       <= scan_in;
         lfsr_ff       <= lfsr_in;
         seed_ff       <= seed_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_valid_ff <= slot_valid_in;
         slot_count_ff <= slot_count_in;
      end
      // payload, no reset needed
      pend_pos_ff   <= pend_pos_in;
      hole_ff       <= hole_in;
      slot_token_ff <= slot_token_in;
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      tok_ff        <= tok_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_tok_ff    <= rsp_tok_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_val_ff    <= rsp_val_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_ctx_index_out = rsp_idx_ff;
   assign rsp_ctx_token_out = rsp_tok_ff;
   assign rsp_key_out       = rsp_key_ff;
   assign rsp_value_out     = rsp_val_ff;

   // only register 0 exists; addresses with paddr[2] set read as zero
   assign prdata = (paddr[2] == CSR_TOKEN_SEED) ? seed_ff : '0;
   assign pready = 1'b1;

   `CKVT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `CKVT_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe held two cycles")
   `CKVT_ASSERT_IMPLIES(a_rsp_idle, rsp_valid, !busy, "result strobe while busy")
   `CKVT_ASSERT_IMPLIES(a_scan_bound, state_ff == ST_SCAN, issue_ff <= cur_cnt, "scan past fill count")
   `CKVT_ASSERT_IMPLIES(a_lfsr_live, 1'b1, lfsr_ff != '0, "token generator stuck at zero")

endmodule
`default_nettype wire
